@@ rtl/mfd_pkg.sv @@
// Shared types, constants and register codes for the motor feedback frame decoder.
package mfd_pkg;

	localparam int ENC_W        = 16;
	localparam int ROUND_W      = 32;
	localparam int ID_W         = 11;
	localparam int LEN_W        = 4;
	localparam int PAYLOAD_W    = 64;
	localparam int CPR_W        = 16;
	localparam int AGAIN_W      = 32;
	localparam int SGAIN_W      = 16;
	localparam int POS_W        = 32;
	localparam int ANGLE_W      = 48;
	localparam int SPEED_W      = 32;
	localparam int CUR_W        = 19;
	localparam int TEMP_W       = 8;
	localparam int CFG_IDX_W    = 4;
	localparam int CFG_DATA_W   = 32;
	localparam int IN_TDATA_W   = 80;
	localparam int IN_TUSER_W   = 2;
	localparam int OUT_TDATA_W  = 176;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [LEN_W-1:0] MIN_FRAME_BYTES  = LEN_W'(8);
	localparam logic signed [ENC_W:0] UNWRAP_LIMIT = (ENC_W+1)'(4096);

	localparam logic [ID_W-1:0]    RX_ID_RST   = ID_W'(513);
	localparam logic [CPR_W-1:0]   CPR_RST     = CPR_W'(8192);
	localparam logic [AGAIN_W-1:0] AGAIN_RST   = AGAIN_W'(3294198);
	localparam logic [SGAIN_W-1:0] SGAIN_RST   = SGAIN_W'(6863);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RX_ID      = 4'd0,
		CFG_CPR        = 4'd1,
		CFG_ANGLE_GAIN = 4'd2,
		CFG_SPEED_GAIN = 4'd3
	} mfd_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_SAT,
		ST_ANG,
		ST_OUT
	} mfd_state_t;

	// One decoded frame waiting for the arithmetic back end
	typedef struct packed {
		logic [ENC_W-1:0]          enc;
		logic signed [ROUND_W-1:0] rounds;
		logic signed [15:0]        rpm;
		logic signed [15:0]        cur;
		logic [TEMP_W-1:0]         temp;
	} mfd_item_t;

	typedef struct packed {
		logic [CPR_W-1:0]   cpr;
		logic [AGAIN_W-1:0] angle_gain;
		logic [SGAIN_W-1:0] speed_gain;
	} mfd_gain_t;

endpackage

@@ rtl/mfd_front.sv @@
// Front end: accepts frame beats, filters them, unpacks the payload and unwraps the encoder.
module mfd_front import mfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic [IN_TUSER_W-1:0] s_axis_tuser,
	input  logic [ID_W-1:0]       rx_id,
	input  logic                  q_full,
	output logic                  q_push,
	output mfd_item_t             q_item
);

	logic [ID_W-1:0]           frame_id;
	logic [LEN_W-1:0]          frame_length;
	logic [PAYLOAD_W-1:0]      payload;
	logic                      is_standard_id;
	logic                      is_data_frame;
	logic                      match;
	logic [ENC_W-1:0]          enc;
	logic signed [ENC_W:0]     diff;
	logic [ENC_W-1:0]          last_enc_q;
	logic                      have_prev_q;
	logic signed [ROUND_W-1:0] rounds_q;
	logic signed [ROUND_W-1:0] rounds_nxt;

	localparam logic signed [ROUND_W-1:0] ROUND_MAX = {1'b0, {(ROUND_W-1){1'b1}}};
	localparam logic signed [ROUND_W-1:0] ROUND_MIN = {1'b1, {(ROUND_W-1){1'b0}}};

	// tdata: frame_id, frame_length, payload; tuser: is_standard_id, is_data_frame
	assign frame_id       = s_axis_tdata[ID_W-1:0];
	assign frame_length   = s_axis_tdata[ID_W+LEN_W-1:ID_W];
	assign payload        = s_axis_tdata[ID_W+LEN_W+PAYLOAD_W-1:ID_W+LEN_W];
	assign is_standard_id = s_axis_tuser[0];
	assign is_data_frame  = s_axis_tuser[1];

	assign match = is_standard_id && is_data_frame && (frame_length >= MIN_FRAME_BYTES)
		&& (frame_id == rx_id);

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && s_axis_tready && match;

	assign enc  = payload[63:48];
	assign diff = $signed({1'b0, enc}) - $signed({1'b0, last_enc_q});

	always_comb begin
		rounds_nxt = rounds_q;
		if (have_prev_q) begin
			if (diff > UNWRAP_LIMIT) begin
				if (rounds_q != ROUND_MIN) rounds_nxt = rounds_q - ROUND_W'(1);
			end else if (diff < -UNWRAP_LIMIT) begin
				if (rounds_q != ROUND_MAX) rounds_nxt = rounds_q + ROUND_W'(1);
			end
		end
	end

	always_comb begin
		q_item.enc    = enc;
		q_item.rounds = rounds_nxt;
		q_item.rpm    = $signed(payload[47:32]);
		q_item.cur    = $signed(payload[31:16]);
		q_item.temp   = payload[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_enc_q  <= '0;
			have_prev_q <= 1'b0;
			rounds_q    <= '0;
		end else if (q_push) begin
			last_enc_q  <= enc;
			have_prev_q <= 1'b1;
			rounds_q    <= rounds_nxt;
		end
	end

	// round counter moves only on a decoded frame
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(q_push) |-> $stable(rounds_q))
		else $error("round counter changed without a decoded frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		!have_prev_q |-> rounds_q == '0)
		else $error("rounds moved before first sample");

endmodule

@@ rtl/mfd_fifo.sv @@
// Short queue between the front end and the arithmetic back end.
module mfd_fifo import mfd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH   // 2 or more
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  mfd_item_t wr_item,
	input  logic      pop,
	output mfd_item_t rd_item,
	output logic      full,
	output logic      empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	mfd_item_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)      count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + CW'(1))
		else $error("queue count missed a push");

endmodule

@@ rtl/mfd_back.sv @@
// Back end: sequenced multiply and saturate steps that build one result beat.
module mfd_back import mfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mfd_item_t              q_item,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  mfd_gain_t              gains,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int PROD1_W = ROUND_W + CPR_W + 1;
	localparam int SUM_W   = PROD1_W + 1;
	localparam int PROD2_W = POS_W + AGAIN_W + 1;
	localparam int PAD_W   = OUT_TDATA_W - (2*POS_W + ANGLE_W + SPEED_W + CUR_W + TEMP_W);

	localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'({1'b0, {(POS_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

	mfd_state_t state_q, state_nxt;

	mfd_item_t                   ent_q;
	logic signed [PROD1_W-1:0]   rcp_s1;
	logic signed [SPEED_W-1:0]   speed_s1;
	logic signed [CUR_W-1:0]     cur_s1;
	logic signed [POS_W-1:0]     pos_s2;
	logic signed [ANGLE_W-1:0]   angle_s3;
	logic                        out_valid_q;
	logic [OUT_TDATA_W-1:0]      out_data_q;

	logic signed [PROD1_W-1:0]   rcp;
	logic signed [SGAIN_W+ENC_W:0] spd_full;
	logic signed [CUR_W-1:0]     cur_ext;
	logic signed [SUM_W-1:0]     pos_sum;
	logic signed [PROD2_W-1:0]   ang_full;
	logic                        out_load;

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					state_nxt = ST_POS;
				end
			end
			ST_POS:  state_nxt = ST_SAT;
			ST_SAT:  state_nxt = ST_ANG;
			ST_ANG:  state_nxt = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nxt;
	end

	// rounds * counts_per_round, rpm * speed_gain, current * 5
	assign rcp      = ent_q.rounds * $signed({1'b0, gains.cpr});
	assign spd_full = ent_q.rpm * $signed({1'b0, gains.speed_gain});
	assign cur_ext  = CUR_W'(ent_q.cur);
	assign pos_sum  = SUM_W'(rcp_s1) + $signed({{(SUM_W-ENC_W){1'b0}}, ent_q.enc});
	assign ang_full = pos_s2 * $signed({1'b0, gains.angle_gain});

	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= q_item;
		if (state_q == ST_POS) begin
			rcp_s1   <= rcp;
			speed_s1 <= SPEED_W'(spd_full);
			cur_s1   <= (cur_ext <<< 2) + cur_ext;
		end
		if (state_q == ST_SAT) begin
			if (pos_sum > POS_MAX)      pos_s2 <= POS_W'(POS_MAX);
			else if (pos_sum < POS_MIN) pos_s2 <= POS_W'(POS_MIN);
			else                        pos_s2 <= POS_W'(pos_sum);
		end
		// floor shift by 16 is just the upper bits of the product
		if (state_q == ST_ANG) angle_s3 <= ang_full[ANGLE_W+15:16];
		if (out_load) begin
			out_data_q <= {{PAD_W{1'b0}}, ent_q.temp, cur_s1, speed_s1, angle_s3,
				ent_q.rounds, pos_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            out_valid_q <= 1'b0;
		else if (out_load)      out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE)
		else $error("queue popped while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_axis_tready))
		else $error("result overwritten before taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_POS) |-> state_q == ST_SAT)
		else $error("sequencer skipped a step");

endmodule

@@ rtl/motor_feedback_frame_decoder_top.sv @@
// Flow: an accepted frame beat is queued; the back-end sequencer pops it, multiplies, saturates,
// multiplies by the angle gain and loads the result beat, and pops the next frame only after that load;
// the load waits while the previous result beat is untaken. The front end takes a frame beat every
// cycle while the queue has room; dropped frames leave no result.
// Reset (arst_n low, async): queue and output empty, unwrap state cleared, registers to defaults.
// Top level: configuration registers plus front end, queue and arithmetic back end.
module motor_feedback_frame_decoder_top import mfd_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // frame_id[10:0], frame_length[14:11], payload[78:15], pad
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // is_standard_id[0], is_data_frame[1]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // total_position[31:0], round_count[63:32],
	                                               // angle[111:64], speed[143:112],
	                                               // current[162:144], temperature[170:163], pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [ID_W-1:0]    rx_id_q;
	mfd_gain_t          gains_q;
	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	mfd_item_t          wr_item;
	mfd_item_t          rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_id_q            <= RX_ID_RST;
			gains_q.cpr        <= CPR_RST;
			gains_q.angle_gain <= AGAIN_RST;
			gains_q.speed_gain <= SGAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RX_ID:      rx_id_q            <= cfg_data[ID_W-1:0];
				CFG_CPR:        gains_q.cpr        <= cfg_data[CPR_W-1:0];
				CFG_ANGLE_GAIN: gains_q.angle_gain <= cfg_data[AGAIN_W-1:0];
				CFG_SPEED_GAIN: gains_q.speed_gain <= cfg_data[SGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	mfd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.rx_id         (rx_id_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (wr_item)
	);

	mfd_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (wr_item),
		.pop     (q_pop),
		.rd_item (rd_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	mfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (rd_item),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.gains         (gains_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

@@ dv/motor_feedback_frame_decoder_top_test.sv @@
// Self-checking bench for the motor feedback frame decoder: frame filter, encoder unwrap, scaling.
module motor_feedback_frame_decoder_top_test;
	import mfd_pkg::*;

	localparam int RESET_CYCLES  = 6;
	localparam int DRAIN_CYCLES  = 16;
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASE_RESULTS = 300;
	localparam int TIMEOUT       = 6_000_000;
	localparam int JUMP_LIMIT    = 4096;
	localparam int CURRENT_SCALE = 5;
	localparam int SPIN_STEP     = JUMP_LIMIT + 1;
	localparam int ROUND_MIN     = 32'sh8000_0000;
	localparam int ROUND_MAX     = 32'sh7FFF_FFFF;
	localparam longint POS_MAX   = 64'sd2147483647;
	localparam longint POS_MIN   = -64'sd2147483648;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = 4'hF;

	typedef struct packed {
		logic signed [POS_W-1:0]   position;
		logic signed [ROUND_W-1:0] rounds;
		logic signed [ANGLE_W-1:0] angle;
		logic signed [SPEED_W-1:0] speed;
		logic signed [CUR_W-1:0]   current;
		logic [TEMP_W-1:0]         temperature;
	} feedback_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	motor_feedback_frame_decoder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// decoder model state and registers
	logic [ID_W-1:0]    cur_rx_id      = RX_ID_RST;
	logic [CPR_W-1:0]   cur_cpr        = CPR_RST;
	logic [AGAIN_W-1:0] cur_angle_gain = AGAIN_RST;
	logic [SGAIN_W-1:0] cur_speed_gain = SGAIN_RST;
	logic [ENC_W-1:0]   last_enc       = '0;
	logic               have_prev      = 1'b0;
	int                 round_ctr      = 0;

	feedback_t expected_feedback[$];
	feedback_t seen;
	feedback_t want;

	int mismatches         = 0;
	int frames_offered     = 0;
	int frames_decoded     = 0;
	int frames_dropped     = 0;
	int results_checked    = 0;
	int round_steps        = 0;
	int position_clamps    = 0;
	int input_stall_cycles = 0;

	// sender pacing and receiver stall control
	bit        bursty     = 1'b0;
	int        burst_left = 0;
	bit        rx_stalls  = 1'b0;
	bit        holding    = 1'b0;
	logic [15:0] stall_pattern = '1;
	logic [3:0]  stall_phase   = '0;
	event      start_holdoff;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(TIMEOUT);
		$display("motor_feedback_frame_decoder_top_test: FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (holding) begin
			m_axis_tready <= 1'b0;
		end else if (!rx_stalls) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pattern = '1;
					1: stall_pattern = 16'($urandom & $urandom);
					default: stall_pattern = 16'($urandom | $urandom);
				endcase
			end
			m_axis_tready <= stall_pattern[stall_phase];
			stall_phase = stall_phase + 1'b1;
		end
	end

	initial forever begin
		@(start_holdoff);
		holding = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding = 1'b0;
	end

	task automatic log_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input longint want_v, input longint got_v);
		if (want_v != got_v)
			log_error($sformatf("result %0d %s: expected %0d, got %0d",
				results_checked, name, want_v, got_v));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.position    = m_axis_tdata[31:0];
			seen.rounds      = m_axis_tdata[63:32];
			seen.angle       = m_axis_tdata[111:64];
			seen.speed       = m_axis_tdata[143:112];
			seen.current     = m_axis_tdata[162:144];
			seen.temperature = m_axis_tdata[170:163];
			if (expected_feedback.size() == 0) begin
				log_error($sformatf("result beat with nothing expected: %h", m_axis_tdata));
			end else begin
				want = expected_feedback.pop_front();
				check_field("total_position", want.position, seen.position);
				check_field("round_count", want.rounds, seen.rounds);
				check_field("angle", want.angle, seen.angle);
				check_field("speed", want.speed, seen.speed);
				check_field("current", want.current, seen.current);
				check_field("temperature", want.temperature, seen.temperature);
				results_checked++;
			end
		end
	end

	// Filter, unwrap and scale one accepted frame; queue the result it should produce.
	task automatic decode_feedback(input logic std_id, input logic data_frame,
		input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
		input logic [PAYLOAD_W-1:0] payload);
		logic [ENC_W-1:0]   enc;
		logic signed [15:0] rpm;
		logic signed [15:0] cur_raw;
		int                 delta;
		longint             pos;
		longint             product;
		longint             speed_l;
		longint             cur_l;
		feedback_t          fb;
		if (!std_id || !data_frame || len < MIN_FRAME_BYTES || id != cur_rx_id) begin
			frames_dropped++;
			return;
		end
		enc     = payload[63:48];
		rpm     = payload[47:32];
		cur_raw = payload[31:16];
		if (have_prev) begin
			delta = int'(enc) - int'(last_enc);
			if (delta > JUMP_LIMIT) begin
				if (round_ctr != ROUND_MIN)
					round_ctr--;
				round_steps++;
			end else if (delta < -JUMP_LIMIT) begin
				if (round_ctr != ROUND_MAX)
					round_ctr++;
				round_steps++;
			end
		end
		last_enc  = enc;
		have_prev = 1'b1;

		pos = longint'(round_ctr) * longint'(cur_cpr) + longint'(enc);
		if (pos > POS_MAX) begin
			pos = POS_MAX;
			position_clamps++;
		end else if (pos < POS_MIN) begin
			pos = POS_MIN;
			position_clamps++;
		end
		product = (pos * longint'(cur_angle_gain)) >>> 16;
		speed_l = longint'(rpm) * longint'(cur_speed_gain);
		cur_l   = longint'(cur_raw) * CURRENT_SCALE;

		fb.position    = pos[POS_W-1:0];
		fb.rounds      = round_ctr;
		fb.angle       = product[ANGLE_W-1:0];
		fb.speed       = speed_l[SPEED_W-1:0];
		fb.current     = cur_l[CUR_W-1:0];
		fb.temperature = payload[15:8];
		expected_feedback.push_back(fb);
		frames_decoded++;
	endtask

	task automatic send_frame(input logic std_id, input logic data_frame,
		input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
		input logic [PAYLOAD_W-1:0] payload);
		if (bursty) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
				burst_left = $urandom_range(0, 24);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, payload, len, id};
		s_axis_tuser  <= {data_frame, std_id};
		do begin
			@(posedge clk);
			if (!s_axis_tready)
				input_stall_cycles++;
		end while (!s_axis_tready);
		frames_offered++;
		decode_feedback(std_id, data_frame, id, len, payload);
	endtask

	// Well-formed feedback frame for the current id; some use long length codes.
	task automatic send_feedback(input logic [ENC_W-1:0] enc, input logic [15:0] rpm,
		input logic [15:0] cur_raw, input logic [TEMP_W-1:0] temp);
		logic [LEN_W-1:0] len;
		len = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(9, 15)) : MIN_FRAME_BYTES;
		send_frame(1'b1, 1'b1, cur_rx_id, len, {enc, rpm, cur_raw, temp, 8'($urandom)});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RX_ID:      cur_rx_id      = value[ID_W-1:0];
			CFG_CPR:        cur_cpr        = value[CPR_W-1:0];
			CFG_ANGLE_GAIN: cur_angle_gain = value[AGAIN_W-1:0];
			CFG_SPEED_GAIN: cur_speed_gain = value[SGAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] rx, input logic [CFG_DATA_W-1:0] cpr,
		input logic [CFG_DATA_W-1:0] again, input logic [CFG_DATA_W-1:0] sgain);
		write_reg(CFG_RX_ID, rx);
		write_reg(CFG_CPR, cpr);
		write_reg(CFG_ANGLE_GAIN, again);
		write_reg(CFG_SPEED_GAIN, sgain);
	endtask

	// Drop valid, wait for every queued result, then let dropped frames flush out.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_feedback.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_frame();
		logic [ENC_W-1:0]     enc;
		logic [PAYLOAD_W-1:0] payload;
		int                   delta;
		int                   choose;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: delta = int'($urandom_range(0, 800)) - 400;
			6, 7: delta = ($urandom_range(0, 1) ? 1 : -1) * (JUMP_LIMIT - 2 + int'($urandom_range(0, 4)));
			default: delta = int'($urandom);
		endcase
		enc     = last_enc + ENC_W'(delta);
		payload = {enc, 16'($urandom), 16'($urandom), 16'($urandom)};
		choose  = $urandom_range(0, 99);
		if (choose < 80) begin
			send_feedback(enc, 16'($urandom), 16'($urandom), 8'($urandom));
		end else if (choose < 92) begin
			case ($urandom_range(0, 3))
				0: send_frame(1'b0, 1'b1, cur_rx_id, MIN_FRAME_BYTES, payload);
				1: send_frame(1'b1, 1'b0, cur_rx_id, MIN_FRAME_BYTES, payload);
				2: send_frame(1'b1, 1'b1, cur_rx_id, LEN_W'($urandom_range(0, 7)), payload);
				default: send_frame(1'b1, 1'b1, cur_rx_id ^ ID_W'($urandom_range(1, 2047)),
					MIN_FRAME_BYTES, payload);
			endcase
		end else begin
			send_frame(1'($urandom), 1'($urandom), ID_W'($urandom), LEN_W'($urandom),
				{$urandom, $urandom});
		end
	endtask

	task automatic test_first_sample();
		// first frame after reset must not unwrap against the cleared last count
		send_feedback(16'hFFFF, 16'h8000, 16'h8000, 8'hFF);
		send_feedback(16'h0000, 16'h7FFF, 16'h7FFF, 8'h00);
		send_feedback(16'hF000, 16'h0001, 16'hFFFF, 8'h80);
	endtask

	task automatic test_frame_filter();
		logic [PAYLOAD_W-1:0] junk;
		junk = 64'h8000_1234_5678_9A00;
		send_frame(1'b0, 1'b1, cur_rx_id, MIN_FRAME_BYTES, junk);
		send_frame(1'b1, 1'b0, cur_rx_id, MIN_FRAME_BYTES, junk);
		send_frame(1'b1, 1'b1, cur_rx_id, MIN_FRAME_BYTES - 1'b1, junk);
		send_frame(1'b1, 1'b1, cur_rx_id, '0, junk);
		send_frame(1'b1, 1'b1, cur_rx_id ^ 1'b1, MIN_FRAME_BYTES, junk);
		send_frame(1'b1, 1'b1, '1, '1, junk);
		send_frame(1'b0, 1'b0, '0, '0, '1);
		// long length codes decode like eight bytes
		send_frame(1'b1, 1'b1, cur_rx_id, '1, 64'hF100_0010_FFF0_2233);
		send_frame(1'b1, 1'b1, cur_rx_id, MIN_FRAME_BYTES + 1'b1, 64'hF180_FFFF_0001_44FF);
		send_frame(1'b1, 1'b1, cur_rx_id, MIN_FRAME_BYTES, 64'hF000_0000_0000_0000);
	endtask

	task automatic test_unwrap_threshold();
		send_feedback(16'd0, 16'd100, 16'd10, 8'd25);     // big drop: one round up
		send_feedback(16'd4096, 16'd100, 16'd10, 8'd25);  // exactly at limit: no step
		send_feedback(16'd8193, 16'd100, 16'd10, 8'd25);  // one past: round down
		send_feedback(16'd4096, 16'd100, 16'd10, 8'd25);  // one past the other way
		send_feedback(16'd8192, 16'd100, 16'd10, 8'd25);
		send_feedback(16'd4096, 16'd100, 16'd10, 8'd25);
		send_feedback(16'hFFFF, 16'd100, 16'd10, 8'd25);
		send_feedback(16'd0, 16'd100, 16'd10, 8'd25);
	endtask

	task automatic test_register_settings();
		for (int i = 0; i < 4; i++) begin
			settle();
			case (i)
				// zero id and counts, all-ones gains, junk above each field narrower than the data word
				0: apply_settings(32'hFFFF_F800, 32'hABCD_0000, 32'hFFFF_FFFF, 32'h1234_FFFF);
				1: apply_settings(32'h0000_07FF, 32'h0000_0001, 32'h0, 32'h0);
				2: apply_settings(32'($urandom), 32'h0000_FFFF, 32'h1, 32'h1);
				default: apply_settings(CFG_DATA_W'(RX_ID_RST), CFG_DATA_W'(CPR_RST),
					CFG_DATA_W'(AGAIN_RST), CFG_DATA_W'(SGAIN_RST));
			endcase
			if (i == 2)
				write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
					32'($urandom));
			send_feedback(16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF);
			send_feedback(16'h0000, 16'h7FFF, 16'h8000, 8'h00);
			send_frame(1'b1, 1'b1, ~cur_rx_id, MIN_FRAME_BYTES, {$urandom, $urandom});
			send_feedback(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		int target;
		for (int phase = 0; phase < 5; phase++) begin
			settle();
			case (phase)
				0: apply_settings(CFG_DATA_W'(RX_ID_RST), CFG_DATA_W'(CPR_RST),
					CFG_DATA_W'(AGAIN_RST), CFG_DATA_W'(SGAIN_RST));
				2: apply_settings($urandom, ($urandom & 32'hFFFF_0000) | $urandom_range(1, 16),
					$urandom, $urandom);
				3: apply_settings($urandom, $urandom & 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0000_FFFF);
				default: apply_settings($urandom, $urandom, $urandom, $urandom);
			endcase
			// first phase runs without idling on either side
			bursty    = (phase != 0);
			rx_stalls = (phase != 0);
			target    = frames_decoded + PHASE_RESULTS;
			while (frames_decoded < target)
				send_random_frame();
		end
		bursty    = 1'b0;
		rx_stalls = 1'b0;
	endtask

	task automatic test_output_holdoff();
		settle();
		-> start_holdoff;
		repeat (30)
			send_feedback(last_enc + 16'($urandom_range(0, 300)), 16'($urandom), 16'($urandom),
				8'($urandom));
	endtask

	task automatic test_wide_gains();
		settle();
		apply_settings(CFG_DATA_W'(cur_rx_id), 32'h0000_FFFF, 32'hFFFF_FFFF, $urandom);
		// every step jumps forward past the limit, so rounds fall (or rise where the count wraps) under the widest gains
		repeat (20)
			send_feedback(last_enc + 16'(SPIN_STEP), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_first_sample();
		test_frame_filter();
		test_unwrap_threshold();
		test_register_settings();
		test_random_traffic();
		test_output_holdoff();
		test_wide_gains();
		settle();

		$display("Run covered %0d frame beats: %0d decoded, %0d dropped, %0d results checked.",
			frames_offered, frames_decoded, frames_dropped, results_checked);
		$display("Round steps %0d, position clamps %0d, input back-pressure cycles %0d, errors %0d.",
			round_steps, position_clamps, input_stall_cycles, mismatches);
		if (mismatches == 0 && expected_feedback.size() == 0) begin
			$display("motor_feedback_frame_decoder_top_test: PASS");
		end else begin
			$display("motor_feedback_frame_decoder_top_test: FAIL");
		end
		$finish;
	end

endmodule
